[hw/rtl/rtc_pkg.sv]
`default_nettype none

package rtc_pkg;

    // item kinds as carried on the mode field
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // compare_mode codes
    localparam logic [1:0] CMP_LE = 2'd0;
    localparam logic [1:0] CMP_GE = 2'd1;
    localparam logic [1:0] CMP_EQ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_COMPARE_MODE = 2'd0;
    localparam logic [1:0] REG_BASE         = 2'd1;
    localparam logic [1:0] REG_STEP         = 2'd2;
    localparam logic [1:0] REG_COUNT        = 2'd3;

    // reset values of the configuration registers
    localparam logic [1:0]  RST_COMPARE_MODE = CMP_GE;
    localparam logic [31:0] RST_BASE         = 32'd0;
    localparam logic [30:0] RST_STEP         = 31'd328;
    localparam logic [8:0]  RST_COUNT        = 9'd200;

    // fraction bits of the rate outputs
    localparam int RATE_FRAC = 16;

    // back to front control
    typedef struct packed {
        logic pop;
        logic init_pass;
    } back_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/rtc_front.sv]
`default_nettype none

module rtc_front
    import rtc_pkg::*;
#(
    parameter int SCORE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [1:0]            mode,
    input  wire logic [SCORE_BITS-1:0] score,
    input  wire logic                  is_positive,
    input  wire logic [7:0]            entry_index,
    input  wire back_ctrl_t            ctrl,
    output logic                       busy,
    output logic                       q_valid,
    output cmd_t                       q_kind,
    output logic [SCORE_BITS-1:0]      q_score,
    output logic                       q_label,
    output logic [7:0]                 q_index
);

    cmd_t                  kind_reg  [2];
    logic [SCORE_BITS-1:0] score_reg [2];
    logic                  label_reg [2];
    logic [7:0]            index_reg [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    logic push;
    logic known;
    cmd_t kind_in;

    // classify: unknown modes are taken and dropped
    always_comb
    begin
        known   = 1'b0;
        kind_in = CMD_SAMPLE;
        unique case (mode)
            CMD_SAMPLE:
            begin
                known   = 1'b1;
                kind_in = CMD_SAMPLE;
            end
            CMD_READ:
            begin
                known   = 1'b1;
                kind_in = CMD_READ;
            end
            CMD_CLEAR:
            begin
                known   = 1'b1;
                kind_in = CMD_CLEAR;
            end
            default:
            begin
                known   = 1'b0;
                kind_in = CMD_SAMPLE;
            end
        endcase
    end

    assign busy    = (fill_reg == 2'd2) || ctrl.init_pass;
    assign push    = start && !busy && known;
    assign q_valid = (fill_reg != 2'd0);
    assign q_kind  = kind_reg[rd_ptr_reg];
    assign q_score = score_reg[rd_ptr_reg];
    assign q_label = label_reg[rd_ptr_reg];
    assign q_index = index_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ ctrl.pop;
        fill_next   = fill_reg + 2'(push) - 2'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_reg[wr_ptr_reg]  <= kind_in;
            score_reg[wr_ptr_reg] <= score;
            label_reg[wr_ptr_reg] <= is_positive;
            index_reg[wr_ptr_reg] <= entry_index;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rtc_div.sv]
`default_nettype none

module rtc_div
    import rtc_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [W-1:0]         num,
    input  wire logic [W-1:0]         den,
    output logic                      done,
    output logic [RATE_FRAC:0]        quo
);

    // restoring division of num * 2^16 by den, num <= den, then round half up
    logic [W:0]             rem_reg, rem_next;
    logic [W-1:0]           den_reg;
    logic [RATE_FRAC-1:0]   q_reg, q_next;
    logic [3:0]             cnt_reg;
    logic                   run_reg;
    logic                   rnd_reg;
    logic                   done_reg;
    logic [RATE_FRAC:0]     quo_reg;

    logic [W:0] shifted;
    logic       qbit;
    logic       round_up;

    always_comb
    begin
        shifted  = {rem_reg[W-1:0], 1'b0};
        qbit     = (shifted >= {1'b0, den_reg});
        rem_next = qbit ? (shifted - {1'b0, den_reg}) : shifted;
        q_next   = {q_reg[RATE_FRAC-2:0], qbit};
        round_up = ({rem_reg[W-1:0], 1'b0} >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 4'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    run_reg <= 1'b0;
                    rnd_reg <= 1'b1;
                end
            end
            else if (rnd_reg)
            begin
                rnd_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
        else if (rnd_reg)
        begin
            quo_reg <= {1'b0, q_reg} + (RATE_FRAC+1)'(round_up);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/rtc_back.sv]
`default_nettype none

module rtc_back
    import rtc_pkg::*;
#(
    parameter int MAX_THRESHOLDS = 256,
    parameter int COUNT_BITS     = 32,
    parameter int SCORE_BITS     = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [1:0]                   cfg_mode,
    input  wire logic signed [31:0]           cfg_base,
    input  wire logic [30:0]                  cfg_step,
    input  wire logic [8:0]                   cfg_count,
    input  wire logic                         q_valid,
    input  wire cmd_t                         q_kind,
    input  wire logic [SCORE_BITS-1:0]        q_score,
    input  wire logic                         q_label,
    input  wire logic [7:0]                   q_index,
    output back_ctrl_t                        ctrl,
    output logic                              result_valid,
    output logic [7:0]                        entry_number,
    output logic signed [SCORE_BITS-1:0]      threshold_value,
    output logic [COUNT_BITS-1:0]             true_pos,
    output logic [COUNT_BITS-1:0]             false_neg,
    output logic [COUNT_BITS-1:0]             false_pos,
    output logic [COUNT_BITS-1:0]             true_neg,
    output logic [RATE_FRAC:0]                tp_rate,
    output logic [RATE_FRAC:0]                fp_rate,
    output logic                              tp_rate_valid,
    output logic                              fp_rate_valid,
    output logic                              index_out_of_range
);

    localparam int IDX_W = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
    localparam int NW    = $clog2(MAX_THRESHOLDS + 1);
    localparam int KW    = (IDX_W > 8) ? IDX_W : 8;
    localparam int TW0   = 32 + KW + 2;
    localparam int TW    = (TW0 > SCORE_BITS + 2) ? TW0 : SCORE_BITS + 2;
    localparam int PW    = 31 + 8;

    localparam logic signed [TW-1:0] SAT_MAX =
        {{(TW-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_MIN =
        {{(TW-SCORE_BITS+1){1'b1}}, {(SCORE_BITS-1){1'b0}}};
    localparam logic [NW-1:0] LAST_ENTRY = NW'(MAX_THRESHOLDS - 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SWEEP = 9'b000000100,
        S_DRAIN = 9'b000001000,
        S_RD0   = 9'b000010000,
        S_RD1   = 9'b000100000,
        S_RD2   = 9'b001000000,
        S_WAIT  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] tp_mem [MAX_THRESHOLDS];
    logic [COUNT_BITS-1:0] fp_mem [MAX_THRESHOLDS];
    logic [COUNT_BITS-1:0] tp_rd_reg, fp_rd_reg;

    logic [NW-1:0]          k_reg, k_next;
    logic signed [TW-1:0]   t_acc_reg, t_acc_next;
    logic [SCORE_BITS-1:0]  score_reg;
    logic                   label_reg;
    logic [7:0]             idx_reg;
    logic                   init_reg, init_next;

    logic                   p_valid_reg;
    logic                   p_hit_reg;
    logic [IDX_W-1:0]       p_addr_reg;

    logic [COUNT_BITS-1:0]  pos_total_reg, pos_total_next;
    logic [COUNT_BITS-1:0]  neg_total_reg, neg_total_next;

    logic [PW-1:0]          prod_reg;
    logic                   oor_reg;
    logic [COUNT_BITS-1:0]  tp_o_reg, fn_o_reg, fp_o_reg, tn_o_reg;
    logic [COUNT_BITS-1:0]  pd_reg, nd_reg;
    logic signed [SCORE_BITS-1:0] thr_reg;

    logic                   res_valid_reg;
    logic [RATE_FRAC:0]     tp_rate_reg, fp_rate_reg;
    logic                   tp_ok_reg, fp_ok_reg;

    logic [NW-1:0]          n_act;
    logic [15:0]            cnt_ext;
    logic signed [TW-1:0]   t_sat;
    logic signed [TW-1:0]   s_ext;
    logic                   hit;
    logic [IDX_W-1:0]       rd_addr;
    logic                   we;
    logic [IDX_W-1:0]       wr_addr;
    logic [COUNT_BITS-1:0]  tp_wd, fp_wd;
    logic                   tp_we, fp_we;
    logic                   pop;
    logic                   div_start;
    logic                   div_a_done, div_b_done;
    logic [RATE_FRAC:0]     div_a_q, div_b_q;
    logic signed [TW-1:0]   rd_thr;
    logic signed [TW-1:0]   rd_thr_sat;

    function automatic logic signed [TW-1:0] sat_thr(input logic signed [TW-1:0] t);
        if (t > SAT_MAX)
            return SAT_MAX;
        else if (t < SAT_MIN)
            return SAT_MIN;
        else
            return t;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    // active threshold count, limited to the table depth
    always_comb
    begin
        cnt_ext = 16'(cfg_count);
        n_act   = (cnt_ext < 16'(MAX_THRESHOLDS)) ? NW'(cnt_ext) : NW'(MAX_THRESHOLDS);
    end

    // sweep compare against the running threshold
    always_comb
    begin
        t_sat = sat_thr(t_acc_reg);
        s_ext = TW'($signed(score_reg));
        hit   = 1'b0;
        unique case (cfg_mode)
            CMP_LE:  hit = (s_ext <= t_sat);
            CMP_GE:  hit = (s_ext >= t_sat);
            CMP_EQ:  hit = (s_ext == t_sat);
            default: hit = 1'b0;
        endcase
    end

    assign rd_thr     = TW'(cfg_base) + $signed(TW'(prod_reg));
    assign rd_thr_sat = sat_thr(rd_thr);

    assign pop = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        t_acc_next     = t_acc_reg;
        init_next      = init_reg;
        pos_total_next = pos_total_reg;
        neg_total_next = neg_total_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                k_next = k_reg + NW'(1);
                if (k_reg == LAST_ENTRY)
                begin
                    state_next = S_IDLE;
                    init_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                k_next     = '0;
                t_acc_next = TW'(cfg_base);
                if (q_valid)
                begin
                    unique case (q_kind)
                        CMD_SAMPLE:
                        begin
                            if (q_label)
                                pos_total_next = sat_inc(pos_total_reg);
                            else
                                neg_total_next = sat_inc(neg_total_reg);
                            state_next = (n_act == '0) ? S_IDLE : S_SWEEP;
                        end
                        CMD_READ:
                            state_next = S_RD0;
                        CMD_CLEAR:
                        begin
                            pos_total_next = '0;
                            neg_total_next = '0;
                            state_next     = S_CLEAR;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SWEEP:
            begin
                k_next     = k_reg + NW'(1);
                t_acc_next = t_acc_reg + $signed(TW'(cfg_step));
                if (k_reg + NW'(1) == n_act)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_IDLE;
            S_RD0:
                state_next = S_RD1;
            S_RD1:
                state_next = S_RD2;
            S_RD2:
                state_next = S_WAIT;
            S_WAIT:
            begin
                if (div_a_done)
                    state_next = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            k_reg         <= '0;
            init_reg      <= 1'b1;
            pos_total_reg <= '0;
            neg_total_reg <= '0;
            p_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            init_reg      <= init_next;
            pos_total_reg <= pos_total_next;
            neg_total_reg <= neg_total_next;
            p_valid_reg   <= (state_reg == S_SWEEP);
            res_valid_reg <= (state_reg == S_OUT);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        t_acc_reg <= t_acc_next;
        p_hit_reg <= hit;
        p_addr_reg <= k_reg[IDX_W-1:0];
        if (pop)
        begin
            score_reg <= q_score;
            label_reg <= q_label;
            idx_reg   <= q_index;
        end
        if (state_reg == S_RD0)
        begin
            prod_reg <= PW'(cfg_step) * PW'(idx_reg);
            oor_reg  <= (16'(idx_reg) >= 16'(n_act));
        end
        if (state_reg == S_RD1)
        begin
            thr_reg <= SCORE_BITS'(rd_thr_sat);
            if (oor_reg)
            begin
                tp_o_reg <= '0;
                fn_o_reg <= '0;
                fp_o_reg <= '0;
                tn_o_reg <= '0;
                pd_reg   <= '0;
                nd_reg   <= '0;
            end
            else
            begin
                tp_o_reg <= tp_rd_reg;
                fp_o_reg <= fp_rd_reg;
                fn_o_reg <= (pos_total_reg >= tp_rd_reg) ? pos_total_reg - tp_rd_reg : '0;
                tn_o_reg <= (neg_total_reg >= fp_rd_reg) ? neg_total_reg - fp_rd_reg : '0;
                // tp + fn is the larger of the two
                pd_reg   <= (pos_total_reg >= tp_rd_reg) ? pos_total_reg : tp_rd_reg;
                nd_reg   <= (neg_total_reg >= fp_rd_reg) ? neg_total_reg : fp_rd_reg;
            end
        end
        if ((state_reg == S_WAIT) && div_a_done)
        begin
            tp_ok_reg   <= (pd_reg != '0);
            fp_ok_reg   <= (nd_reg != '0);
            tp_rate_reg <= (pd_reg != '0) ? div_a_q : '0;
            fp_rate_reg <= (nd_reg != '0) ? div_b_q : '0;
        end
    end

    // count tables
    assign rd_addr = (state_reg == S_SWEEP) ? k_reg[IDX_W-1:0] : IDX_W'(idx_reg);
    assign we      = p_valid_reg && p_hit_reg;
    assign tp_we   = (state_reg == S_CLEAR) || (we && label_reg);
    assign fp_we   = (state_reg == S_CLEAR) || (we && !label_reg);
    assign wr_addr = (state_reg == S_CLEAR) ? k_reg[IDX_W-1:0] : p_addr_reg;
    assign tp_wd   = (state_reg == S_CLEAR) ? '0 : sat_inc(tp_rd_reg);
    assign fp_wd   = (state_reg == S_CLEAR) ? '0 : sat_inc(fp_rd_reg);

    always_ff @(posedge clk)
    begin
        if (tp_we)
            tp_mem[wr_addr] <= tp_wd;
        tp_rd_reg <= tp_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fp_we)
            fp_mem[wr_addr] <= fp_wd;
        fp_rd_reg <= fp_mem[rd_addr];
    end

    assign div_start = (state_reg == S_RD2);

    rtc_div #(
        .W(COUNT_BITS)
    ) u_div_tp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (tp_o_reg),
        .den   (pd_reg),
        .done  (div_a_done),
        .quo   (div_a_q)
    );

    rtc_div #(
        .W(COUNT_BITS)
    ) u_div_fp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (fp_o_reg),
        .den   (nd_reg),
        .done  (div_b_done),
        .quo   (div_b_q)
    );

    assign ctrl = '{pop: pop, init_pass: init_reg};

    assign result_valid       = res_valid_reg;
    assign entry_number       = idx_reg;
    assign threshold_value    = thr_reg;
    assign true_pos           = tp_o_reg;
    assign false_neg          = fn_o_reg;
    assign false_pos          = fp_o_reg;
    assign true_neg           = tn_o_reg;
    assign tp_rate            = tp_rate_reg;
    assign fp_rate            = fp_rate_reg;
    assign tp_rate_valid      = tp_ok_reg;
    assign fp_rate_valid      = fp_ok_reg;
    assign index_out_of_range = oor_reg;

    // both dividers run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_a_done == div_b_done)
        else $error("rate dividers out of step");

    // a result strobe lasts one cycle
    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // no table update outside a sweep and its drain
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == S_SWEEP || state_reg == S_DRAIN))
        else $error("count update outside a sweep");

    // requests leave the queue only when the back end is idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !init_reg)
        else $error("request taken during clearing pass");

endmodule

`default_nettype wire

[hw/rtl/roc_threshold_counter.sv]
// channel     | signals                                          | handshake
// ------------+--------------------------------------------------+------------------------
// request     | mode, score, is_positive, entry_index            | start & !busy
// result      | entry_number .. index_out_of_range               | result_valid, one cycle
// config      | cfg_index, cfg_data                              | cfg_valid & cfg_ready
//
// in the back end a sample does one table read-modify-write per active threshold, one
// after another, over the single read port of each count table
// a read waits on the 16-step rate dividers; a clear zeroes all MAX_THRESHOLDS entries of both tables
// after reset a clearing pass over every table entry holds busy high; config is taken meanwhile
// a two-deep request queue lets the front accept while the back works; results cannot be stalled
`default_nettype none

module roc_threshold_counter
    import rtc_pkg::*;
#(
    parameter int MAX_THRESHOLDS = 256,
    parameter int COUNT_BITS     = 32,
    parameter int SCORE_BITS     = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   mode,
    input  wire logic [SCORE_BITS-1:0]        score,
    input  wire logic                         is_positive,
    input  wire logic [7:0]                   entry_index,
    // config channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [31:0]                  cfg_data,
    // result channel
    output logic                              result_valid,
    output logic [7:0]                        entry_number,
    output logic signed [SCORE_BITS-1:0]      threshold_value,
    output logic [COUNT_BITS-1:0]             true_pos,
    output logic [COUNT_BITS-1:0]             false_neg,
    output logic [COUNT_BITS-1:0]             false_pos,
    output logic [COUNT_BITS-1:0]             true_neg,
    output logic [RATE_FRAC:0]                tp_rate,
    output logic [RATE_FRAC:0]                fp_rate,
    output logic                              tp_rate_valid,
    output logic                              fp_rate_valid,
    output logic                              index_out_of_range
);

    // configuration registers
    logic [1:0]         cmp_mode_reg;
    logic signed [31:0] base_reg;
    logic [30:0]        step_reg;
    logic [8:0]         count_reg;

    logic                  q_valid;
    cmd_t                  q_kind;
    logic [SCORE_BITS-1:0] q_score;
    logic                  q_label;
    logic [7:0]            q_index;
    back_ctrl_t            ctrl;

    // writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_mode_reg <= RST_COMPARE_MODE;
            base_reg     <= RST_BASE;
            step_reg     <= RST_STEP;
            count_reg    <= RST_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COMPARE_MODE: cmp_mode_reg <= cfg_data[1:0];
                REG_BASE:         base_reg     <= cfg_data;
                REG_STEP:         step_reg     <= cfg_data[30:0];
                REG_COUNT:        count_reg    <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    // front: takes requests, drops unknown kinds, queues the rest
    rtc_front #(
        .SCORE_BITS(SCORE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .score       (score),
        .is_positive (is_positive),
        .entry_index (entry_index),
        .ctrl        (ctrl),
        .busy        (busy),
        .q_valid     (q_valid),
        .q_kind      (q_kind),
        .q_score     (q_score),
        .q_label     (q_label),
        .q_index     (q_index)
    );

    // back: threshold sweeps, clears and table reads
    rtc_back #(
        .MAX_THRESHOLDS (MAX_THRESHOLDS),
        .COUNT_BITS     (COUNT_BITS),
        .SCORE_BITS     (SCORE_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_mode           (cmp_mode_reg),
        .cfg_base           (base_reg),
        .cfg_step           (step_reg),
        .cfg_count          (count_reg),
        .q_valid            (q_valid),
        .q_kind             (q_kind),
        .q_score            (q_score),
        .q_label            (q_label),
        .q_index            (q_index),
        .ctrl               (ctrl),
        .result_valid       (result_valid),
        .entry_number       (entry_number),
        .threshold_value    (threshold_value),
        .true_pos           (true_pos),
        .false_neg          (false_neg),
        .false_pos          (false_pos),
        .true_neg           (true_neg),
        .tp_rate            (tp_rate),
        .fp_rate            (fp_rate),
        .tp_rate_valid      (tp_rate_valid),
        .fp_rate_valid      (fp_rate_valid),
        .index_out_of_range (index_out_of_range)
    );

endmodule

`default_nettype wire

[test/roc_threshold_counter_tb.sv]
`default_nettype none

module roc_threshold_counter_tb;
    import rtc_pkg::*;

    localparam int NUM_THRESH = 256;
    localparam longint unsigned COUNT_TOP = 64'hFFFF_FFFF;
    localparam longint SCORE_TOP = 64'sh7FFF_FFFF;
    localparam longint SCORE_BOTTOM = -64'sh8000_0000;
    // item mode the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // compare mode that never classes anything positive
    localparam logic [1:0] CMP_NONE = 2'd3;
    // cycles with nothing accepted before the run is declared hung
    localparam int HANG_LIMIT = 5000;
    // long enough for two queued clears plus one in flight to drain
    localparam int SETTLE_CYCLES = 900;

    // one read response as seen on the result ports
    typedef struct {
        logic [7:0]  entry;
        logic [31:0] thresh;
        logic [31:0] tp;
        logic [31:0] fn;
        logic [31:0] fp;
        logic [31:0] tn;
        logic [16:0] tp_q;
        logic [16:0] fp_q;
        logic        tp_ok;
        logic        fp_ok;
        logic        oor;
    } roc_report_t;

    // tracks the per-threshold counts and predicts every read response
    class roc_tally;
        logic [1:0]      cmp_mode;
        longint          base;
        longint unsigned step;
        int unsigned     count;
        longint unsigned tp_cnt[NUM_THRESH];
        longint unsigned fp_cnt[NUM_THRESH];
        longint unsigned pos_total;
        longint unsigned neg_total;
        roc_report_t     pending_reports[$];
        string           mismatches[$];

        function void reset_state();
            cmp_mode = RST_COMPARE_MODE;
            base = 0;
            step = 328;
            count = 200;
            clear_counts();
        endfunction

        function void clear_counts();
            for (int k = 0; k < NUM_THRESH; k++)
            begin
                tp_cnt[k] = 0;
                fp_cnt[k] = 0;
            end
            pos_total = 0;
            neg_total = 0;
        endfunction

        function void add_mismatch(string m);
            mismatches = {mismatches, m};
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_COMPARE_MODE: cmp_mode = data[1:0];
                REG_BASE:         base = longint'($signed(data));
                REG_STEP:         step = longint'(data[30:0]);
                REG_COUNT:        count = 32'(data[8:0]);
                default: ;
            endcase
        endfunction

        function int unsigned active();
            return (count < NUM_THRESH) ? count : NUM_THRESH;
        endfunction

        function longint threshold_at(int unsigned k);
            longint t;
            t = base + longint'(step * k);
            if (t > SCORE_TOP)
                t = SCORE_TOP;
            if (t < SCORE_BOTTOM)
                t = SCORE_BOTTOM;
            return t;
        endfunction

        function bit hits(longint s, longint t);
            case (cmp_mode)
                CMP_LE:  return s <= t;
                CMP_GE:  return s >= t;
                CMP_EQ:  return s == t;
                default: return 1'b0;
            endcase
        endfunction

        function logic [16:0] q16(longint unsigned num, longint unsigned den);
            longint unsigned q;
            longint unsigned r;
            q = (num << 16) / den;
            r = (num << 16) % den;
            if (2 * r >= den)
                q++;
            return q[16:0];
        endfunction

        function longint unsigned bump(longint unsigned c);
            return (c < COUNT_TOP) ? c + 1 : c;
        endfunction

        // called for every accepted request
        function void note_request(logic [1:0] md, logic [31:0] sc, logic pos,
                                   logic [7:0] idx);
            roc_report_t r;
            longint unsigned tp;
            longint unsigned fp;
            longint unsigned fn;
            longint unsigned tn;
            longint s;
            s = longint'($signed(sc));
            case (md)
                CMD_SAMPLE:
                begin
                    for (int unsigned k = 0; k < active(); k++)
                        if (hits(s, threshold_at(k)))
                        begin
                            if (pos)
                                tp_cnt[k] = bump(tp_cnt[k]);
                            else
                                fp_cnt[k] = bump(fp_cnt[k]);
                        end
                    if (pos)
                        pos_total = bump(pos_total);
                    else
                        neg_total = bump(neg_total);
                end
                CMD_CLEAR: clear_counts();
                CMD_READ:
                begin
                    r.entry = idx;
                    r.thresh = 32'(threshold_at(idx));
                    r.tp = 0; r.fn = 0; r.fp = 0; r.tn = 0;
                    r.tp_q = 0; r.fp_q = 0; r.tp_ok = 0; r.fp_ok = 0;
                    r.oor = (idx >= active());
                    if (!r.oor)
                    begin
                        tp = tp_cnt[idx];
                        fp = fp_cnt[idx];
                        fn = (pos_total >= tp) ? pos_total - tp : 0;
                        tn = (neg_total >= fp) ? neg_total - fp : 0;
                        r.tp = 32'(tp); r.fn = 32'(fn); r.fp = 32'(fp); r.tn = 32'(tn);
                        if (tp + fn != 0)
                        begin
                            r.tp_q = q16(tp, tp + fn);
                            r.tp_ok = 1;
                        end
                        if (fp + tn != 0)
                        begin
                            r.fp_q = q16(fp, fp + tn);
                            r.fp_ok = 1;
                        end
                    end
                    pending_reports = {pending_reports, r};
                end
                default: ;
            endcase
        endfunction

        // compares one response against the oldest prediction
        function void check_report(roc_report_t got);
            roc_report_t w;
            if (pending_reports.size() == 0)
            begin
                add_mismatch($sformatf("response for entry %0d with none pending",
                                       got.entry));
                return;
            end
            w = pending_reports.pop_front();
            if (got.entry !== w.entry)
                add_mismatch($sformatf("entry_number %0d, want %0d", got.entry, w.entry));
            if (got.thresh !== w.thresh)
                add_mismatch($sformatf("entry %0d threshold_value %h, want %h",
                                       w.entry, got.thresh, w.thresh));
            if (got.tp !== w.tp)
                add_mismatch($sformatf("entry %0d true_pos %0d, want %0d",
                                       w.entry, got.tp, w.tp));
            if (got.fn !== w.fn)
                add_mismatch($sformatf("entry %0d false_neg %0d, want %0d",
                                       w.entry, got.fn, w.fn));
            if (got.fp !== w.fp)
                add_mismatch($sformatf("entry %0d false_pos %0d, want %0d",
                                       w.entry, got.fp, w.fp));
            if (got.tn !== w.tn)
                add_mismatch($sformatf("entry %0d true_neg %0d, want %0d",
                                       w.entry, got.tn, w.tn));
            if (got.tp_q !== w.tp_q)
                add_mismatch($sformatf("entry %0d tp_rate %h, want %h",
                                       w.entry, got.tp_q, w.tp_q));
            if (got.fp_q !== w.fp_q)
                add_mismatch($sformatf("entry %0d fp_rate %h, want %h",
                                       w.entry, got.fp_q, w.fp_q));
            if (got.tp_ok !== w.tp_ok)
                add_mismatch($sformatf("entry %0d tp_rate_valid %b, want %b",
                                       w.entry, got.tp_ok, w.tp_ok));
            if (got.fp_ok !== w.fp_ok)
                add_mismatch($sformatf("entry %0d fp_rate_valid %b, want %b",
                                       w.entry, got.fp_ok, w.fp_ok));
            if (got.oor !== w.oor)
                add_mismatch($sformatf("entry %0d index_out_of_range %b, want %b",
                                       w.entry, got.oor, w.oor));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] mode;
    logic [31:0] score;
    logic is_positive;
    logic [7:0] entry_index;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    logic result_valid;
    logic [7:0] entry_number;
    logic signed [31:0] threshold_value;
    logic [31:0] true_pos;
    logic [31:0] false_neg;
    logic [31:0] false_pos;
    logic [31:0] true_neg;
    logic [16:0] tp_rate;
    logic [16:0] fp_rate;
    logic tp_rate_valid;
    logic fp_rate_valid;
    logic index_out_of_range;

    roc_tally tally;
    int fail_count;
    int quiet_cycles;

    roc_threshold_counter i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .mode               (mode),
        .score              (score),
        .is_positive        (is_positive),
        .entry_index        (entry_index),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .result_valid       (result_valid),
        .entry_number       (entry_number),
        .threshold_value    (threshold_value),
        .true_pos           (true_pos),
        .false_neg          (false_neg),
        .false_pos          (false_pos),
        .true_neg           (true_neg),
        .tp_rate            (tp_rate),
        .fp_rate            (fp_rate),
        .tp_rate_valid      (tp_rate_valid),
        .fp_rate_valid      (fp_rate_valid),
        .index_out_of_range (index_out_of_range)
    );

    // 12 unit period
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    // results cannot be held off, so every strobe is checked at the edge that ends it
    always @(posedge clk)
    begin
        roc_report_t got;
        if (rst_n && result_valid)
        begin
            got.entry = entry_number;
            got.thresh = threshold_value;
            got.tp = true_pos;
            got.fn = false_neg;
            got.fp = false_pos;
            got.tn = true_neg;
            got.tp_q = tp_rate;
            got.fp_q = fp_rate;
            got.tp_ok = tp_rate_valid;
            got.fp_ok = fp_rate_valid;
            got.oor = index_out_of_range;
            tally.check_report(got);
            while (tally.mismatches.size() > 0)
                report(tally.mismatches.pop_front());
        end
    end

    // hang detector: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one request; start stays high when the caller asks for no gap afterwards
    task automatic send_request(logic [1:0] md, logic [31:0] sc, logic pos, logic [7:0] idx);
        @(negedge clk);
        start = 1'b1;
        mode = md;
        score = sc;
        is_positive = pos;
        entry_index = idx;
        do
            @(posedge clk);
        while (busy);
        tally.note_request(md, sc, pos, idx);
    endtask

    // mostly short gaps, now and then a long one, often none at all
    task automatic sender_gap();
        int g;
        case ($urandom_range(9))
            0, 1, 2, 3: g = 0;
            4, 5, 6, 7: g = $urandom_range(1, 3);
            8:          g = $urandom_range(4, 12);
            default:    g = $urandom_range(20, 60);
        endcase
        if (g > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        start = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tally.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // samples and clears leave no trace on the result side, so wait out the back end too
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (tally.pending_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [1:0] cm, logic [31:0] b, logic [30:0] st, logic [8:0] cnt);
        settle();
        // upper bits are junk the block must drop
        write_reg(REG_COMPARE_MODE, {30'($urandom), cm});
        write_reg(REG_BASE, b);
        write_reg(REG_STEP, {1'($urandom_range(1)), st});
        write_reg(REG_COUNT, {23'($urandom), cnt});
    endtask

    // scores near a threshold most of the time so that every comparison flips
    function automatic logic [31:0] pick_score();
        longint t;
        int unsigned k;
        if ($urandom_range(9) < 6)
        begin
            k = $urandom_range(0, tally.active() + 1);
            t = tally.threshold_at(k);
            case ($urandom_range(3))
                0:       return 32'(t);
                1:       return 32'(t + 1);
                2:       return 32'(t - 1);
                default: return 32'(t + $signed($urandom_range(0, 400)) - 200);
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_items(int num);
        int unsigned r;
        logic [7:0] idx;
        for (int i = 0; i < num; i++)
        begin
            r = $urandom_range(99);
            if (r < 70)
                send_request(CMD_SAMPLE, pick_score(), 1'($urandom), 8'($urandom));
            else if (r < 94)
            begin
                if ($urandom_range(3) != 0 && tally.active() > 0)
                    idx = 8'($urandom_range(0, tally.active() - 1));
                else
                    idx = 8'($urandom);
                send_request(CMD_READ, $urandom, 1'($urandom), idx);
            end
            else if (r < 97)
                send_request(CMD_CLEAR, $urandom, 1'($urandom), 8'($urandom));
            else
                send_request(CMD_UNUSED, $urandom, 1'($urandom), 8'($urandom));
            sender_gap();
            // hold back until every read has answered
            if ($urandom_range(60) == 0)
                settle();
        end
    endtask

    initial
    begin
        tally = new();
        tally.reset_state();
        fail_count = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = CMD_SAMPLE;
        score = '0;
        is_positive = 1'b0;
        entry_index = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_COMPARE_MODE;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, empty tables, extremes, ignored mode, clear
        send_request(CMD_READ, '0, 1'b0, 8'd0);
        send_request(CMD_SAMPLE, 32'd0, 1'b1, 8'd0);
        send_request(CMD_SAMPLE, 32'h7FFF_FFFF, 1'b0, 8'hFF);
        send_request(CMD_SAMPLE, 32'h8000_0000, 1'b1, 8'd0);
        send_request(CMD_SAMPLE, 32'd65272, 1'b1, 8'd0);
        send_request(CMD_SAMPLE, 32'd65271, 1'b0, 8'd0);
        send_request(CMD_READ, '0, 1'b0, 8'd0);
        send_request(CMD_READ, '0, 1'b0, 8'd199);
        send_request(CMD_READ, '0, 1'b0, 8'd200);
        send_request(CMD_READ, '1, 1'b1, 8'd255);
        send_request(CMD_UNUSED, 32'd5, 1'b1, 8'd3);
        send_request(CMD_READ, '0, 1'b0, 8'd1);
        send_request(CMD_CLEAR, '0, 1'b0, 8'd0);
        send_request(CMD_READ, '0, 1'b0, 8'd0);
        send_request(CMD_SAMPLE, 32'd400, 1'b0, 8'd0);
        send_request(CMD_READ, '0, 1'b0, 8'd1);

        // settings sweep: every compare mode, count extremes, threshold saturation at the top end
        configure(CMP_LE, -32'sd5000, 31'd100, 9'd1);
        random_items(90);
        configure(CMP_EQ, 32'd0, 31'd0, 9'd256);
        random_items(110);
        configure(CMP_NONE, $urandom, 31'($urandom_range(1, 5000)), 9'd50);
        random_items(90);
        configure(CMP_GE, 32'h8000_0000, 31'h7FFF_FFFF, 9'd256);
        random_items(110);
        configure(CMP_LE, 32'h7FFF_FF00, 31'd1000, 9'd511);
        random_items(110);
        configure(CMP_GE, 32'd0, 31'd328, 9'd0);
        random_items(60);
        configure(CMP_EQ, -32'sd1000, 31'd10, 9'd100);
        random_items(110);
        configure(2'($urandom_range(0, 2)), $urandom, 31'($urandom_range(0, 1 << 20)),
                  9'($urandom_range(1, 256)));
        random_items(200);

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
